FILE: hdl/afhs_pkg.sv
`default_nettype none
package afhs_pkg;

	localparam int HEAD_LEN  = 10;
	localparam int FRAME_MAX = 1024;

	localparam int IDX_W  = $clog2(HEAD_LEN);
	localparam int FILL_W = $clog2(HEAD_LEN + 1);
	localparam int CNT_W  = $clog2(FRAME_MAX);

	localparam int         NUM_TITLES = 4;
	localparam int         TITLE_MAX  = 8;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_LF      = 8'h0a;

	// Titles in priority order; the index is the message type.
	localparam logic [7:0] TITLE_TEXT [NUM_TITLES][TITLE_MAX] = '{
		'{"$", "i", "n", "i", "t", "a", "c", "k"},
		'{"$", "p", "i", "n", "g", 8'h00, 8'h00, 8'h00},
		'{"$", "p", "o", "n", "g", 8'h00, 8'h00, 8'h00},
		'{"$", "m", "e", "s", "s", "a", "g", "e"}
	};
	localparam int TITLE_LEN [NUM_TITLES] = '{8, 5, 5, 8};

	typedef logic [HEAD_LEN-1:0][7:0] win_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [7:0]       wr_data;
		logic             shift;
	} win_ctrl_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] hit_type;
		logic [7:0] head0;
		logic       next_is_dollar;
	} win_stat_t;

	typedef struct packed {
		logic       frame_abort;
		logic       frame_end;
		logic [1:0] msg_type;
		logic [7:0] running_xor;
		logic [7:0] frame_byte;
	} out_item_t;

	function automatic logic title_match(win_t w, int t);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < TITLE_MAX; k++) begin
			if (k < TITLE_LEN[t] && k < HEAD_LEN && w[k] != TITLE_TEXT[t][k]) ok = 1'b0;
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/afhs_window.sv
`default_nettype none
module afhs_window (
	input  wire logic                clk,
	input  wire afhs_pkg::win_ctrl_t ctrl,
	output afhs_pkg::win_stat_t      stat
);

	afhs_pkg::win_t win_q;

	// Shift toward entry zero, or write one entry.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int j = 0; j < afhs_pkg::HEAD_LEN - 1; j++) win_q[j] <= win_q[j+1];
		end else if (ctrl.wr_en) begin
			win_q[ctrl.wr_idx] <= ctrl.wr_data;
		end
	end

	// Lowest matching title wins.
	always_comb begin
		stat.hit      = 1'b0;
		stat.hit_type = '0;
		for (int t = afhs_pkg::NUM_TITLES - 1; t >= 0; t--) begin
			if (afhs_pkg::title_match(win_q, t)) begin
				stat.hit      = 1'b1;
				stat.hit_type = 2'(t);
			end
		end
		stat.head0          = win_q[0];
		stat.next_is_dollar = (win_q[1] == afhs_pkg::CH_DOLLAR);
	end

endmodule
`default_nettype wire

FILE: hdl/afhs_seq.sv
`default_nettype none
module afhs_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,
	input  wire logic                slot_free,
	input  wire afhs_pkg::win_stat_t stat,
	output afhs_pkg::win_ctrl_t      ctrl,
	output logic                     push,
	output afhs_pkg::out_item_t      item
);

	afhs_pkg::state_t                state_q, state_d;
	logic [afhs_pkg::FILL_W-1:0]     fill_q;
	logic                            in_body_q;
	logic [afhs_pkg::CNT_W-1:0]      count_q;
	logic [afhs_pkg::CNT_W-1:0]      cnt_inc;
	logic [7:0]                      xor_q;
	logic [7:0]                      prior_q;
	logic [1:0]                      type_q;
	logic [afhs_pkg::IDX_W-1:0]      emit_q;
	logic                            s_fire;
	logic                            emit_go;
	logic                            body_abort;
	logic                            body_end;

	assign s_fire     = s_tvalid && s_tready;
	assign emit_go    = (state_q == afhs_pkg::ST_EMIT) && slot_free;
	assign cnt_inc    = count_q + afhs_pkg::CNT_W'(1);
	assign body_abort = cnt_inc >= afhs_pkg::CNT_W'(afhs_pkg::FRAME_MAX - 1);
	assign body_end   = !body_abort && s_tdata == afhs_pkg::CH_LF &&
		prior_q == afhs_pkg::CH_CR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			afhs_pkg::ST_IDLE: begin
				if (s_fire && !in_body_q &&
					fill_q == afhs_pkg::FILL_W'(afhs_pkg::HEAD_LEN - 1)) state_d = afhs_pkg::ST_CHECK;
			end
			afhs_pkg::ST_CHECK: begin
				state_d = stat.hit ? afhs_pkg::ST_EMIT : afhs_pkg::ST_SCAN;
			end
			afhs_pkg::ST_SCAN: begin
				if (stat.next_is_dollar || fill_q == afhs_pkg::FILL_W'(1)) state_d = afhs_pkg::ST_IDLE;
			end
			afhs_pkg::ST_EMIT: begin
				if (slot_free && emit_q == afhs_pkg::IDX_W'(afhs_pkg::HEAD_LEN - 1))
					state_d = afhs_pkg::ST_IDLE;
			end
			default: state_d = afhs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == afhs_pkg::ST_IDLE) && slot_free;
		ctrl.wr_en   = s_fire && !in_body_q;
		ctrl.wr_idx  = fill_q[afhs_pkg::IDX_W-1:0];
		ctrl.wr_data = s_tdata;
		ctrl.shift   = (state_q == afhs_pkg::ST_SCAN) || emit_go;
		push         = (s_fire && in_body_q) || emit_go;
		if (state_q == afhs_pkg::ST_EMIT) begin
			item.frame_byte  = stat.head0;
			item.msg_type    = type_q;
			item.frame_end   = 1'b0;
			item.frame_abort = 1'b0;
			item.running_xor = xor_q ^ stat.head0;
		end else begin
			item.frame_byte  = s_tdata;
			item.msg_type    = type_q;
			item.frame_end   = body_end;
			item.frame_abort = body_abort;
			item.running_xor = xor_q ^ s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= afhs_pkg::ST_IDLE;
			fill_q    <= '0;
			in_body_q <= 1'b0;
			count_q   <= '0;
			xor_q     <= '0;
			prior_q   <= '0;
			type_q    <= '0;
			emit_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				afhs_pkg::ST_IDLE: begin
					if (s_fire && in_body_q) begin
						count_q <= cnt_inc;
						xor_q   <= xor_q ^ s_tdata;
						prior_q <= s_tdata;
						if (body_abort || body_end) in_body_q <= 1'b0;
					end else if (s_fire) begin
						fill_q <= fill_q + afhs_pkg::FILL_W'(1);
					end
				end
				afhs_pkg::ST_CHECK: begin
					if (stat.hit) begin
						type_q <= stat.hit_type;
						xor_q  <= '0;
						emit_q <= '0;
					end
				end
				afhs_pkg::ST_SCAN: begin
					fill_q <= fill_q - afhs_pkg::FILL_W'(1);
				end
				afhs_pkg::ST_EMIT: begin
					if (slot_free) begin
						xor_q  <= xor_q ^ stat.head0;
						emit_q <= emit_q + afhs_pkg::IDX_W'(1);
						if (emit_q == afhs_pkg::IDX_W'(afhs_pkg::HEAD_LEN - 1)) begin
							prior_q   <= stat.head0;
							count_q   <= afhs_pkg::CNT_W'(afhs_pkg::HEAD_LEN);
							fill_q    <= '0;
							in_body_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free) else $error("item pushed into a full output slot");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= afhs_pkg::FILL_W'(afhs_pkg::HEAD_LEN)) else $error("head fill out of range");
	a_body_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> fill_q == '0) else $error("head window not empty in body");
	a_end_abort: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(item.frame_end && item.frame_abort)) else $error("end and abort together");

endmodule
`default_nettype wire

FILE: hdl/ascii_frame_header_search.sv
// Channel  Dir  Width  Content
// s_*      in   8      tdata: data_byte [7:0]
// m_*      out  16+3+1 tdata: frame_byte [7:0], running_xor [15:8];
//                      tuser: msg_type [1:0], frame_abort [2]; tlast: frame_end
//
// Searching and body bytes are taken directly while the output slot is free.
// The byte that fills the head window leads to a compare step, then either a
// scan that shifts the window one position per step (up to HEAD_LEN, the full
// count when no later '$' is found) or an emit of the HEAD_LEN head bytes,
// one per step, all through the single window shift path.
// Reset is asynchronous; the window itself is not cleared and is read only
// below the fill count. A stalled output holds the block: no new item is
// taken until the output slot is free or being freed.
`default_nettype none
module ascii_frame_header_search (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] frame_byte, [15:8] running_xor
	output logic [2:0]       m_tuser,   // [1:0] msg_type, [2] frame_abort
	output logic             m_tlast
);

	afhs_pkg::win_ctrl_t win_ctrl;
	afhs_pkg::win_stat_t win_stat;
	afhs_pkg::out_item_t item;
	afhs_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                push;
	logic                slot_free;

	// The slot is free when empty or when the held item leaves this cycle.
	assign slot_free = !out_valid_q || m_tready;

	afhs_window u_window (
		.clk  (clk),
		.ctrl (win_ctrl),
		.stat (win_stat)
	);

	afhs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.slot_free (slot_free),
		.stat      (win_stat),
		.ctrl      (win_ctrl),
		.push      (push),
		.item      (item)
	);

	// Output register: load on push, drop the valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= item;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.running_xor, out_q.frame_byte};
	assign m_tuser  = {out_q.frame_abort, out_q.msg_type};
	assign m_tlast  = out_q.frame_end;

endmodule
`default_nettype wire

FILE: verif/ascii_frame_header_search_tb.sv
`timescale 1ns / 100ps

module ascii_frame_header_search_tb;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int LONG_HOLD    = 400;   // receiver hold-off, long enough to back up the input
	localparam int RAND_ITEMS   = 150;
	localparam int QUIET_AFTER  = 110;   // no idling from here to the end of the random part

	// Message type is the index of the title that matched, in priority order.
	typedef enum logic [1:0] {
		MT_INITACK,
		MT_PING,
		MT_PONG,
		MT_MESSAGE
	} msg_kind_t;

	// Frame tracker: mirrors the search/body state, queues the frame bytes each
	// input byte should produce, and compares them as they leave the block.
	class frame_scoreboard;
		logic [7:0]          win [afhs_pkg::HEAD_LEN];
		int                  fill;
		bit                  in_body;
		int                  count;
		logic [7:0]          xsum;
		logic [7:0]          prior;
		msg_kind_t           kind;
		afhs_pkg::out_item_t frame_q [$];
		int                  errors, n_in, n_checked, n_frames, n_closed, n_dropped;

		function new();
			fill = 0;
			in_body = 0;
			count = 0;
			xsum = '0;
			prior = '0;
			kind = MT_INITACK;
			errors = 0;
			n_in = 0;
			n_checked = 0;
			n_frames = 0;
			n_closed = 0;
			n_dropped = 0;
		endfunction

		function string title_text(msg_kind_t t);
			case (t)
				MT_INITACK: return "$initack";
				MT_PING:    return "$ping";
				MT_PONG:    return "$pong";
				default:    return "$message";
			endcase
		endfunction

		// First title that the window starts with, or -1.
		function int title_hit();
			string s;
			bit    ok;
			for (int t = 0; t < 4; t++) begin
				s = title_text(msg_kind_t'(t));
				ok = 1'b1;
				for (int k = 0; k < s.len() && k < afhs_pkg::HEAD_LEN; k++)
					if (win[k] != s[k]) ok = 1'b0;
				if (ok) return t;
			end
			return -1;
		endfunction

		function void queue_frame_byte(logic [7:0] b, logic fend, logic fabort);
			afhs_pkg::out_item_t e;
			e.frame_byte  = b;
			e.msg_type    = kind;
			e.frame_end   = fend;
			e.frame_abort = fabort;
			e.running_xor = xsum;
			frame_q.push_back(e);
		endfunction

		// Advance the tracker by one accepted input byte.
		function void note_byte(logic [7:0] ch);
			int t, i;
			n_in++;
			if (!in_body) begin
				if (fill >= afhs_pkg::HEAD_LEN) fill = 0;
				win[fill] = ch;
				fill++;
				if (fill < afhs_pkg::HEAD_LEN) return;
				t = title_hit();
				if (t >= 0) begin
					// Head matched: replay the whole window and open the body.
					kind = msg_kind_t'(t);
					xsum = '0;
					for (i = 0; i < afhs_pkg::HEAD_LEN; i++) begin
						xsum ^= win[i];
						queue_frame_byte(win[i], 1'b0, 1'b0);
					end
					prior = win[afhs_pkg::HEAD_LEN-1];
					count = afhs_pkg::HEAD_LEN;
					fill = 0;
					in_body = 1;
					n_frames++;
					return;
				end
				// No title: slide down to the next '$' past the front, else clear.
				for (i = 1; i < afhs_pkg::HEAD_LEN; i++)
					if (win[i] == afhs_pkg::CH_DOLLAR) break;
				if (i < afhs_pkg::HEAD_LEN) begin
					for (int j = 0; j < afhs_pkg::HEAD_LEN - i; j++) win[j] = win[j+i];
					fill = afhs_pkg::HEAD_LEN - i;
				end else begin
					fill = 0;
				end
				return;
			end
			count++;
			xsum ^= ch;
			if (count >= afhs_pkg::FRAME_MAX - 1) begin
				// Length limit wins over CR LF.
				queue_frame_byte(ch, 1'b0, 1'b1);
				in_body = 0;
				n_dropped++;
			end else if (ch == afhs_pkg::CH_LF && prior == afhs_pkg::CH_CR) begin
				queue_frame_byte(ch, 1'b1, 1'b0);
				in_body = 0;
				n_closed++;
			end else begin
				queue_frame_byte(ch, 1'b0, 1'b0);
			end
			fill = 0;
			prior = ch;
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] seen);
			if (want !== seen) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
			end
		endfunction

		// Compare one output item against the oldest queued frame byte.
		function void check_item(afhs_pkg::out_item_t got);
			afhs_pkg::out_item_t e;
			n_checked++;
			if (frame_q.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: unexpected item, expected nothing, actual byte %h xor %h",
						$time, got.frame_byte, got.running_xor);
				return;
			end
			e = frame_q.pop_front();
			cmp_field("frame_byte", e.frame_byte, got.frame_byte);
			cmp_field("msg_type", 8'(e.msg_type), 8'(got.msg_type));
			cmp_field("frame_end", 8'(e.frame_end), 8'(got.frame_end));
			cmp_field("frame_abort", 8'(e.frame_abort), 8'(got.frame_abort));
			cmp_field("running_xor", e.running_xor, got.running_xor);
		endfunction

		function int pending();
			return frame_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;   // [7:0] frame_byte, [15:8] running_xor
	logic [2:0]  m_tuser;   // [1:0] msg_type, [2] frame_abort
	logic        m_tlast;   // frame_end

	frame_scoreboard sb;
	bit quiet    = 1'b0;    // set: neither side idles
	bit hold_req = 1'b0;    // set once to make the receiver do the long hold-off
	int rand_start;

	ascii_frame_header_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: end the run if it hangs.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d frame bytes still due", cycles, sb.pending());
		$display("status: fail");
		$finish;
	end

	// Offer one byte; keep tvalid high across back-to-back items, drop it only
	// for an idle burst.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic close_frame();
		send_byte(afhs_pkg::CH_CR);
		send_byte(afhs_pkg::CH_LF);
	endtask

	// Random byte with a fair share of '$', CR and LF mixed in.
	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(0, 9))
			0:       return afhs_pkg::CH_DOLLAR;
			1:       return afhs_pkg::CH_CR;
			2:       return afhs_pkg::CH_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Well-formed frame: random title, random head padding, short random body.
	task automatic send_random_frame();
		string ttl;
		int    body_n;
		ttl = sb.title_text(msg_kind_t'($urandom_range(0, 3)));
		send_text(ttl);
		for (int k = ttl.len(); k < afhs_pkg::HEAD_LEN; k++)
			send_byte(8'($urandom_range(0, 255)));
		body_n = $urandom_range(0, 16);
		for (int k = 0; k < body_n; k++) send_byte(noisy_byte());
		close_frame();
	endtask

	// Broken head: a cut-off title followed by noise.
	task automatic send_broken_head();
		string ttl;
		int    cut;
		ttl = sb.title_text(msg_kind_t'($urandom_range(0, 3)));
		cut = $urandom_range(1, ttl.len() - 1);
		for (int k = 0; k < cut; k++) send_byte(ttl[k]);
		repeat ($urandom_range(0, 12)) send_byte(noisy_byte());
	endtask

	// Receiver: check each output item, stall in random bursts, and do the one
	// long hold-off when asked.
	initial begin
		int                  stall_left;
		afhs_pkg::out_item_t got;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.frame_byte  = m_tdata[7:0];
				got.running_xor = m_tdata[15:8];
				got.msg_type    = m_tuser[1:0];
				got.frame_abort = m_tuser[2];
				got.frame_end   = m_tlast;
				sb.check_item(got);
			end
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 18);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		sb = new();
		rand_start = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every title, byte extremes, and the edge cases of the search.
		send_text("$initack12");
		send_text("ok");
		close_frame();
		send_text("$ping");
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h7f);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'hff);
		send_byte(8'h00);
		close_frame();
		// Head ends in CR, so the first body byte LF closes the frame.
		send_text("$pongabcd");
		close_frame();
		// Lone CR and CR CR inside the body must not end the frame.
		send_text("$message!!");
		send_text("a");
		send_byte(afhs_pkg::CH_CR);
		send_text("b");
		send_byte(afhs_pkg::CH_CR);
		close_frame();
		// No '$' at all: clear the window.
		send_text("abcdefghij");
		// '$' only at the front: clear the window.
		send_text("$pixxxxxxx");
		// Two slides down to later '$' before the title lines up.
		send_text("zz$pi$pong");
		send_text("abxyz");
		close_frame();

		// Random part: mostly good frames, some broken heads and noise. Start
		// with the long receiver hold-off so the block backs up its input.
		hold_req = 1'b1;
		rand_start = sb.n_in;
		while (sb.n_in - rand_start < RAND_ITEMS) begin
			if (sb.n_in - rand_start >= QUIET_AFTER) quiet = 1'b1;
			case ($urandom_range(0, 9))
				0:       send_broken_head();
				1:       repeat ($urandom_range(1, 15)) send_byte(noisy_byte());
				default: send_random_frame();
			endcase
		end
		// Close any frame a noisy tail may have left open.
		send_text("$pingfinal");
		close_frame();
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any stray output.
		while (sb.pending() != 0) @(posedge clk);
		repeat (4 * afhs_pkg::HEAD_LEN) @(posedge clk);

		$display("run: %0d input bytes, %0d output items checked", sb.n_in, sb.n_checked);
		$display("run: %0d heads found, %0d frames closed by CR LF, %0d dropped at length limit",
			sb.n_frames, sb.n_closed, sb.n_dropped);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
